// ===== src/sdaa_pkg.sv =====
package sdaa_pkg;

  localparam int ADC_BITS_DEF  = 12;
  localparam int TICK_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int DEB_W      = 16;
  localparam int INTV_W     = 16;
  localparam int SPA_W      = 8;
  localparam int GAIN_W     = 24;
  localparam int BAT_W      = 16;
  localparam int FRAC_BITS  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN     = 2'd3;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 16'd50;
  localparam logic [INTV_W-1:0] INTERVAL_RST = 16'd100;
  localparam logic [SPA_W-1:0]  SAMPLES_RST  = 8'd8;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 24'd65536;

  typedef struct packed {
    logic load_tick;
    logic div_step;
    logic mul;
    logic rnd;
    logic load_out;
  } sdaa_cmd_t;

  typedef struct packed {
    logic avg_done;
  } sdaa_stat_t;

endpackage

// ===== src/sdaa_if.sv =====
interface sdaa_in_if #(
  parameter int AdcBits = sdaa_pkg::ADC_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic               switch_raw;
  logic [AdcBits-1:0] adc_code;
  logic [AdcBits-1:0] adc_millivolts;

  modport source (output valid, switch_raw, adc_code, adc_millivolts, input ready);
  modport sink   (input valid, switch_raw, adc_code, adc_millivolts, output ready);
endinterface

interface sdaa_out_if #(
  parameter int AdcBits = sdaa_pkg::ADC_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        switch_stable;
  logic [AdcBits-1:0]          last_adc_code;
  logic [AdcBits-1:0]          average_millivolts;
  logic [sdaa_pkg::BAT_W-1:0]  battery_millivolts;
  logic                        reading_ready;
  logic                        new_reading;

  modport source (output valid, switch_stable, last_adc_code, average_millivolts,
                  battery_millivolts, reading_ready, new_reading, input ready);
  modport sink   (input valid, switch_stable, last_adc_code, average_millivolts,
                  battery_millivolts, reading_ready, new_reading, output ready);
endinterface

// ===== src/sdaa_ctrl.sv =====
module sdaa_ctrl #(
  parameter int SumBits = sdaa_pkg::ADC_BITS_DEF + sdaa_pkg::SPA_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  sdaa_pkg::sdaa_stat_t stat_i,
  output sdaa_pkg::sdaa_cmd_t  cmd_o
);
  import sdaa_pkg::*;

  localparam int CntW = $clog2(SumBits);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_RND  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_tick = 1'b1;
          cnt_d           = CntW'(SumBits - 1);
          state_d         = stat_i.avg_done ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_RND;
      end
      ST_RND: begin
        cmd_o.rnd = 1'b1;
        state_d   = ST_DONE;
      end
      ST_DONE: begin
        // result register free or emptied this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/sdaa_dp.sv =====
module sdaa_dp #(
  parameter int AdcBits  = sdaa_pkg::ADC_BITS_DEF,
  parameter int TickBits = sdaa_pkg::TICK_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [sdaa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sdaa_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               switch_raw_i,
  input  logic [AdcBits-1:0]                 adc_code_i,
  input  logic [AdcBits-1:0]                 adc_millivolts_i,
  input  sdaa_pkg::sdaa_cmd_t                cmd_i,
  output sdaa_pkg::sdaa_stat_t               stat_o,
  output logic                               switch_stable_o,
  output logic [AdcBits-1:0]                 last_adc_code_o,
  output logic [AdcBits-1:0]                 average_millivolts_o,
  output logic [sdaa_pkg::BAT_W-1:0]         battery_millivolts_o,
  output logic                               reading_ready_o,
  output logic                               new_reading_o
);
  import sdaa_pkg::*;

  localparam int SumW = AdcBits + SPA_W;
  localparam int CmpW = (TickBits > DEB_W) ? TickBits : DEB_W;
  localparam int ProdW = AdcBits + GAIN_W;
  localparam int HiW = ProdW + 1 - FRAC_BITS;

  // configuration
  logic [DEB_W-1:0]  debounce_q;
  logic [INTV_W-1:0] interval_q;
  logic [SPA_W-1:0]  spa_q;
  logic [GAIN_W-1:0] gain_q;

  // tick state
  logic                last_sw_q, stable_q, ready_q, fresh_q;
  logic [TickBits-1:0] tsc_q, tss_q;
  logic [SumW-1:0]     sum_q;
  logic [SPA_W-1:0]    cnt_q;
  logic [AdcBits-1:0]  code_q, avg_q;
  logic [BAT_W-1:0]    bat_q;

  // divide and scale
  logic [SumW-1:0]  num_q;
  logic [SPA_W-1:0] den_q;
  logic [SPA_W-1:0] rem_q;
  logic [ProdW-1:0] prod_q;

  logic [TickBits-1:0] tsc_inc, tsc_new, tss_inc;
  logic                deb_hit, smp_hit, avg_hit, stable_new;
  logic [SumW-1:0]     sum_new;
  logic [SPA_W-1:0]    cnt_new;
  logic [SPA_W:0]      rem_sh;
  logic                rem_ge;
  logic [ProdW:0]      rsum;
  logic [HiW-1:0]      bat_wide;

  always_comb begin
    tsc_inc    = (tsc_q == '1) ? tsc_q : tsc_q + 1'b1;
    tsc_new    = (switch_raw_i != last_sw_q) ? '0 : tsc_inc;
    deb_hit    = CmpW'(tsc_new) >= CmpW'(debounce_q);
    stable_new = deb_hit ? switch_raw_i : stable_q;
    tss_inc    = (tss_q == '1) ? tss_q : tss_q + 1'b1;
    smp_hit    = CmpW'(tss_inc) >= CmpW'(interval_q);
    sum_new    = sum_q + SumW'(adc_millivolts_i);
    cnt_new    = cnt_q + 1'b1;
    avg_hit    = smp_hit && (cnt_new != '0) && (cnt_new >= spa_q);
    rem_sh     = {rem_q, num_q[SumW-1]};
    rem_ge     = rem_sh >= {1'b0, den_q};
    rsum       = {1'b0, prod_q} + (ProdW + 1)'(1 << (FRAC_BITS - 1));
    bat_wide   = rsum[ProdW:FRAC_BITS];
  end

  assign stat_o.avg_done = avg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RST;
      interval_q <= INTERVAL_RST;
      spa_q      <= SAMPLES_RST;
      gain_q     <= GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE: debounce_q <= cfg_data_i[DEB_W-1:0];
        CFG_INTERVAL: interval_q <= cfg_data_i[INTV_W-1:0];
        CFG_SAMPLES:  spa_q      <= cfg_data_i[SPA_W-1:0];
        CFG_GAIN:     gain_q     <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sw_q <= 1'b0;
      stable_q  <= 1'b0;
      tsc_q     <= '0;
      tss_q     <= '1;
      sum_q     <= '0;
      cnt_q     <= '0;
      code_q    <= '0;
      avg_q     <= '0;
      bat_q     <= '0;
      ready_q   <= 1'b0;
      fresh_q   <= 1'b0;
    end else begin
      if (cmd_i.load_tick) begin
        last_sw_q <= switch_raw_i;
        tsc_q     <= tsc_new;
        stable_q  <= stable_new;
        fresh_q   <= avg_hit;
        if (smp_hit) begin
          tss_q  <= '0;
          code_q <= adc_code_i;
          if (avg_hit) begin
            sum_q   <= '0;
            cnt_q   <= '0;
            ready_q <= 1'b1;
          end else begin
            sum_q <= sum_new;
            cnt_q <= cnt_new;
          end
        end else begin
          tss_q <= tss_inc;
        end
      end
      if (cmd_i.mul) begin
        avg_q <= num_q[AdcBits-1:0];
      end
      if (cmd_i.rnd) begin
        bat_q <= (|bat_wide[HiW-1:BAT_W]) ? '1 : bat_wide[BAT_W-1:0];
      end
    end
  end

  // restoring divider, quotient bits shift into the numerator register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_tick) begin
      num_q <= sum_new;
      den_q <= cnt_new;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? SPA_W'(rem_sh - {1'b0, den_q}) : rem_sh[SPA_W-1:0];
      num_q <= {num_q[SumW-2:0], rem_ge};
    end
    if (cmd_i.mul) begin
      prod_q <= ProdW'(num_q[AdcBits-1:0]) * ProdW'(gain_q);
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      switch_stable_o      <= stable_q;
      last_adc_code_o      <= code_q;
      average_millivolts_o <= avg_q;
      battery_millivolts_o <= bat_q;
      reading_ready_o      <= ready_q;
      new_reading_o        <= fresh_q;
    end
  end

endmodule

// ===== src/switch_debounce_and_adc_averager.sv =====
// Ignition switch debouncer and block-averaging battery voltmeter.
// One input transfer is one millisecond tick: raw switch level, converter
// code and converter millivolts. Each tick gives exactly one result transfer
// with the debounced level, the last sampled code, the latest average, the
// scaled and saturated battery millivolts, the sticky ready flag and a flag
// that marks the tick which completed an average.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i, by the
// user only while no tick is in flight; the block does not enforce it. Index
// 0 debounce ticks, 1 sample interval, 2 samples per average, 3 gain in
// unsigned Q8.16.
// A tick that completes no average goes from idle straight to the done state;
// one that completes an average first passes the bit-serial divider, one step
// per numerator bit (ADC_BITS + 8), then one multiply and one rounding step.
// Only one tick is in the block at a time; the next waits for the last result.
// The result sits in an output register; a stalled receiver holds it there
// and the block stops taking ticks only once a second result is waiting.
// Reset restores configuration, tick and control registers (not the divider or
// output data), empties the output register and makes the first tick sample.
module switch_debounce_and_adc_averager #(
  parameter int ADC_BITS          = sdaa_pkg::ADC_BITS_DEF,
  parameter int TICK_COUNTER_BITS = sdaa_pkg::TICK_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sdaa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sdaa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sdaa_in_if.sink                         in_if,
  sdaa_out_if.source                      out_if
);
  import sdaa_pkg::*;

  sdaa_cmd_t  cmd;
  sdaa_stat_t stat;

  sdaa_ctrl #(
    .SumBits (ADC_BITS + SPA_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  sdaa_dp #(
    .AdcBits  (ADC_BITS),
    .TickBits (TICK_COUNTER_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .switch_raw_i         (in_if.switch_raw),
    .adc_code_i           (in_if.adc_code),
    .adc_millivolts_i     (in_if.adc_millivolts),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .switch_stable_o      (out_if.switch_stable),
    .last_adc_code_o      (out_if.last_adc_code),
    .average_millivolts_o (out_if.average_millivolts),
    .battery_millivolts_o (out_if.battery_millivolts),
    .reading_ready_o      (out_if.reading_ready),
    .new_reading_o        (out_if.new_reading)
  );

endmodule

// ===== tb/switch_debounce_and_adc_averager_test.sv =====
`timescale 1ns / 100ps

module switch_debounce_and_adc_averager_test;
  import sdaa_pkg::*;

  localparam int AW = ADC_BITS_DEF;
  localparam int TW = TICK_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 32;

  typedef struct packed {
    logic          switch_raw;
    logic [AW-1:0] adc_code;
    logic [AW-1:0] adc_millivolts;
  } tick_t;

  typedef struct packed {
    logic             switch_stable;
    logic [AW-1:0]    last_adc_code;
    logic [AW-1:0]    average_millivolts;
    logic [BAT_W-1:0] battery_millivolts;
    logic             reading_ready;
    logic             new_reading;
  } reading_t;

  typedef enum logic {
    PLAN_TICK,
    PLAN_CFG
  } plan_op_e;

  typedef struct packed {
    plan_op_e              op;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    tick_t                 tick;
    logic                  checked;
    reading_t              want;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  sdaa_in_if  in_ch ();
  sdaa_out_if out_ch ();

  switch_debounce_and_adc_averager i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_ch),
    .out_if     (out_ch)
  );

  // register copies
  logic [DEB_W-1:0]  p_debounce;
  logic [INTV_W-1:0] p_interval;
  logic [SPA_W-1:0]  p_samples;
  logic [GAIN_W-1:0] p_gain;

  // meter state
  logic             p_last_sw;
  logic             p_stable;
  logic [TW-1:0]    p_since_change;
  logic [TW-1:0]    p_since_sample;
  logic [AW+7:0]    p_sum;
  logic [7:0]       p_count;
  logic [AW-1:0]    p_code;
  logic [AW-1:0]    p_avg;
  logic [BAT_W-1:0] p_bat;
  logic             p_ready;

  reading_t  pending_readings[$];
  plan_row_t plan[$];
  reading_t  got_want;
  int        n_fail;
  int        dead_cycles;
  bit        calm;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void meter_reset();
    p_debounce     = DEBOUNCE_RST;
    p_interval     = INTERVAL_RST;
    p_samples      = SAMPLES_RST;
    p_gain         = GAIN_RST;
    p_last_sw      = 1'b0;
    p_stable       = 1'b0;
    p_since_change = '0;
    p_since_sample = '1;
    p_sum          = '0;
    p_count        = '0;
    p_code         = '0;
    p_avg          = '0;
    p_bat          = '0;
    p_ready        = 1'b0;
  endfunction

  function automatic reading_t advance_meter(tick_t t);
    reading_t      r;
    logic [TW-1:0] next_elapsed;
    logic [39:0]   scaled;
    r.new_reading = 1'b0;
    if (t.switch_raw != p_last_sw) begin
      p_last_sw      = t.switch_raw;
      p_since_change = '0;
    end else if (p_since_change != '1) begin
      p_since_change = p_since_change + 1'b1;
    end
    if (p_since_change >= p_debounce) begin
      p_stable = p_last_sw;
    end
    next_elapsed = (p_since_sample == '1) ? p_since_sample : p_since_sample + 1'b1;
    if (next_elapsed >= p_interval) begin
      p_since_sample = '0;
      p_code  = t.adc_code;
      p_sum   = p_sum + t.adc_millivolts;
      p_count = p_count + 1'b1;
      // a lowered register completes the block at once, dividing by the real count
      if (p_count != 0 && p_count >= p_samples) begin
        p_avg   = AW'(p_sum / p_count);
        scaled  = (40'(p_avg) * 40'(p_gain) + 40'd32768) >> FRAC_BITS;
        p_bat   = (scaled > 40'hFFFF) ? 16'hFFFF : scaled[15:0];
        p_sum   = '0;
        p_count = '0;
        p_ready = 1'b1;
        r.new_reading = 1'b1;
      end
    end else begin
      p_since_sample = next_elapsed;
    end
    r.switch_stable      = p_stable;
    r.last_adc_code      = p_code;
    r.average_millivolts = p_avg;
    r.battery_millivolts = p_bat;
    r.reading_ready      = p_ready;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 149) == 0) begin
      calm = !calm;
    end
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [AW-1:0] pick_adc();
    case ($urandom_range(0, 9))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      default: begin
        return AW'($urandom);
      end
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_fail++;
    end
  endfunction

  function automatic plan_row_t tick_row(logic sw, logic [AW-1:0] code, logic [AW-1:0] mv);
    plan_row_t row;
    row         = '0;
    row.op      = PLAN_TICK;
    row.tick    = '{sw, code, mv};
    return row;
  endfunction

  function automatic plan_row_t tick_chk(logic sw, logic [AW-1:0] code, logic [AW-1:0] mv,
                                         reading_t want);
    plan_row_t row;
    row         = tick_row(sw, code, mv);
    row.checked = 1'b1;
    row.want    = want;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row     = '0;
    row.op  = PLAN_CFG;
    row.idx = idx;
    row.val = val;
    return row;
  endfunction

  task automatic send_tick(input tick_t t, input logic checked, input reading_t want);
    int       gap;
    reading_t r;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.switch_raw     <= t.switch_raw;
    in_ch.adc_code       <= t.adc_code;
    in_ch.adc_millivolts <= t.adc_millivolts;
    do @(posedge clk_i); while (!in_ch.ready);
    r = advance_meter(t);
    pending_readings.push_back(checked ? want : r);
  endtask

  // drop valid and wait for every reading still owed
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: begin
        p_debounce = val[DEB_W-1:0];
      end
      CFG_INTERVAL: begin
        p_interval = val[INTV_W-1:0];
      end
      CFG_SAMPLES: begin
        p_samples = val[SPA_W-1:0];
      end
      CFG_GAIN: begin
        p_gain = val[GAIN_W-1:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic random_phase(input int count);
    logic [CFG_DATA_W-1:0] v;
    tick_t                 t;
    logic                  lvl;
    int                    run;
    int                    span;
    settle();
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 16'hFFFF;
      2: v = $urandom_range(0, 65535);
      default: v = $urandom_range(1, 12);
    endcase
    write_reg(CFG_DEBOUNCE, v);
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 16'hFFFF;
      2: v = $urandom_range(6, 40);
      default: v = $urandom_range(1, 5);
    endcase
    write_reg(CFG_INTERVAL, v);
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = 255;
      2: v = 1;
      default: v = $urandom_range(2, 8);
    endcase
    write_reg(CFG_SAMPLES, v);
    case ($urandom_range(0, 7))
      0: v = 0;
      1: v = 24'hFFFFFF;
      2: v = GAIN_RST;
      default: v = $urandom_range(0, 24'hFFFFFF);
    endcase
    write_reg(CFG_GAIN, v);
    lvl = p_last_sw;
    run = 0;
    repeat (count) begin
      // runs of up to 2 * debounce + 3 (20 past 16), with single-tick glitches
      if (run == 0) begin
        lvl  = ~lvl;
        span = (p_debounce > 16) ? 20 : 2 * p_debounce + 3;
        run  = $urandom_range(1, span);
      end
      run--;
      t.switch_raw     = lvl ^ ($urandom_range(0, 15) == 0);
      t.adc_code       = pick_adc();
      t.adc_millivolts = pick_adc();
      send_tick(t, 1'b0, '0);
      if ($urandom_range(0, 249) == 0) begin
        settle();
      end
    end
  endtask

  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: reading with nothing pending, expected none, got new_reading %0d",
                 $time, out_ch.new_reading);
        n_fail++;
      end else begin
        got_want = pending_readings.pop_front();
        check_field("switch_stable", got_want.switch_stable, out_ch.switch_stable);
        check_field("last_adc_code", got_want.last_adc_code, out_ch.last_adc_code);
        check_field("average_millivolts", got_want.average_millivolts,
                    out_ch.average_millivolts);
        check_field("battery_millivolts", got_want.battery_millivolts,
                    out_ch.battery_millivolts);
        check_field("reading_ready", got_want.reading_ready, out_ch.reading_ready);
        check_field("new_reading", got_want.new_reading, out_ch.new_reading);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      dead_cycles = 0;
    end else begin
      dead_cycles++;
    end
    if (dead_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, dead_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_DEBOUNCE;
    cfg_data_i           = '0;
    in_ch.valid          = 1'b0;
    in_ch.switch_raw     = 1'b0;
    in_ch.adc_code       = '0;
    in_ch.adc_millivolts = '0;
    n_fail               = 0;
    dead_cycles          = 0;
    calm                 = 1'b0;
    meter_reset();

    plan = '{
      // first tick samples straight after reset
      tick_chk(1'b0, 12'd4095, 12'd4095, reading_t'{1'b0, 12'd4095, 12'd0, 16'd0, 1'b0, 1'b0}),
      tick_chk(1'b1, 12'd0, 12'd0, reading_t'{1'b0, 12'd4095, 12'd0, 16'd0, 1'b0, 1'b0}),
      cfg_row(CFG_DEBOUNCE, 0),
      cfg_row(CFG_INTERVAL, 0),
      cfg_row(CFG_SAMPLES, 1),
      cfg_row(CFG_GAIN, 24'hFFFFFF),
      // zero debounce follows the raw level, full gain saturates
      tick_chk(1'b1, 12'd0, 12'd4095, reading_t'{1'b1, 12'd0, 12'd4095, 16'hFFFF, 1'b1, 1'b1}),
      tick_chk(1'b0, 12'd4095, 12'd0, reading_t'{1'b0, 12'd4095, 12'd0, 16'd0, 1'b1, 1'b1}),
      // zero samples per average acts as one
      cfg_row(CFG_SAMPLES, 0),
      cfg_row(CFG_GAIN, 0),
      tick_chk(1'b1, 12'd1234, 12'd1000,
               reading_t'{1'b1, 12'd1234, 12'd1000, 16'd0, 1'b1, 1'b1}),
      cfg_row(CFG_DEBOUNCE, 3),
      cfg_row(CFG_SAMPLES, 255),
      cfg_row(CFG_GAIN, GAIN_RST),
      tick_row(1'b0, 12'h555, 12'd100),
      tick_row(1'b0, 12'hAAA, 12'd200),
      tick_row(1'b0, 12'h001, 12'd300),
      tick_row(1'b0, 12'h800, 12'd401),
      // lowered mid-block
      cfg_row(CFG_SAMPLES, 2),
      tick_row(1'b0, 12'hFFE, 12'd7),
      cfg_row(CFG_GAIN, 24'h008000),
      cfg_row(CFG_SAMPLES, 1),
      tick_row(1'b1, 12'h000, 12'd1),
      tick_row(1'b1, 12'hFFF, 12'd4095),
      cfg_row(CFG_INTERVAL, 2),
      tick_row(1'b1, 12'h123, 12'd2222),
      tick_row(1'b1, 12'h456, 12'd3333),
      tick_row(1'b1, 12'h789, 12'd17),
      tick_row(1'b0, 12'hABC, 12'd4000)
    };

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[k]) begin
      if (plan[k].op == PLAN_CFG) begin
        settle();
        write_reg(plan[k].idx, plan[k].val);
      end else begin
        send_tick(plan[k].tick, plan[k].checked, plan[k].want);
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      random_phase(115);
    end

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_fail == 0 && pending_readings.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
